### rtl/radial_circle_alpha_mask_top_assert.svh
// Assertion macros shared by the RTL; each expects clk and rst in scope.
`ifndef RADIAL_CIRCLE_ALPHA_MASK_TOP_ASSERT_SVH
`define RADIAL_CIRCLE_ALPHA_MASK_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rcam_pkg.sv
// ----------------------------------------------------------------------------
// rcam_pkg
// Types and constants for the radial circle alpha mask pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcam_pkg;

  localparam int MAX_CIRCLES = 16;
  localparam int SLOT_W      = 4;
  localparam int CX_W        = 12;
  localparam int CY_W        = 11;
  localparam int R_W         = 12;
  localparam int CNT_W       = 5;
  localparam int PX_W        = 8;
  localparam int PY_W        = 7;
  localparam int FRAC_BITS   = 4;
  localparam int ALPHA_W     = 8;
  localparam int FULL_ALPHA  = 255;
  localparam int ALPHA_SQ    = 65025;
  localparam int ALPHA_SQ_W  = 16;

  localparam int D_W   = CX_W;                 // abs difference width
  localparam int D2_W  = 2 * D_W + 1;          // dx^2 + dy^2
  localparam int R2_W  = 2 * R_W;              // r^2
  localparam int LIM_W = D2_W + ALPHA_SQ_W;    // 65025 * d2
  localparam int ACC_W = LIM_W + 1;            // a^2 * r2 candidate
  localparam int AR_W  = R2_W + ALPHA_W;       // a * r2
  localparam int LAT   = 12;                   // accept edge to result strobe

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_SHADE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [CX_W-1:0]   center_x;
    logic [CY_W-1:0]   center_y;
    logic [R_W-1:0]    radius;
    logic [CNT_W-1:0]  circle_count;
    logic [PX_W-1:0]   pixel_x;
    logic [PY_W-1:0]   pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               inside_res;
    logic [SLOT_W-1:0]  matched_slot;
  } out_item_t;

  typedef struct packed {
    logic            en;
    logic [D2_W-1:0] d2;
    logic [R2_W-1:0] r2;
  } lane_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [D2_W-1:0]   d2;
    logic [R2_W-1:0]   r2;
  } sel_t;

endpackage

### rtl/rcam_table.sv
// ----------------------------------------------------------------------------
// rcam_table
// Circle table, active count, and per-circle squared distance lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcam_table import rcam_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     acc,
  input  in_item_t item,
  output logic     v2,
  output lane_t    lanes [MAX_CIRCLES]
);

  logic [CX_W-1:0]  cx [MAX_CIRCLES];
  logic [CY_W-1:0]  cy [MAX_CIRCLES];
  logic [R_W-1:0]   r  [MAX_CIRCLES];
  logic [CNT_W-1:0] active_count;

  logic [CX_W-1:0]  px_s;
  logic [CY_W-1:0]  py_s;

  logic             v1;
  logic [D_W-1:0]   dx1 [MAX_CIRCLES];
  logic [D_W-1:0]   dy1 [MAX_CIRCLES];
  logic [R_W-1:0]   r1  [MAX_CIRCLES];
  logic             en1 [MAX_CIRCLES];

  assign px_s = CX_W'({item.pixel_x, {FRAC_BITS{1'b0}}});
  assign py_s = CY_W'({item.pixel_y, {FRAC_BITS{1'b0}}});

  // Table writes land at the accept edge; shades sample the old contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CIRCLES; i++) begin
        cx[i] <= '0;
        cy[i] <= '0;
        r[i]  <= '0;
      end
      active_count <= '0;
    end else if (acc) begin
      case (item.action)
        ACT_WRITE: begin
          if (int'(item.slot) < MAX_CIRCLES) begin
            cx[item.slot] <= item.center_x;
            cy[item.slot] <= item.center_y;
            r[item.slot]  <= item.radius;
          end
        end
        ACT_COUNT: begin
          active_count <= (item.circle_count > CNT_W'(MAX_CIRCLES)) ?
                          CNT_W'(MAX_CIRCLES) : item.circle_count;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= acc && (item.action == ACT_SHADE);
      v2 <= v1;
    end
  end

  for (genvar m = 0; m < MAX_CIRCLES; m++) begin : g_lane
    logic [D_W-1:0] dx_c;
    logic [D_W-1:0] dy_c;

    assign dx_c = (px_s >= cx[m]) ? (px_s - cx[m]) : (cx[m] - px_s);
    assign dy_c = (py_s >= cy[m]) ? D_W'(py_s - cy[m]) : D_W'(cy[m] - py_s);

    always_ff @(posedge clk) begin
      dx1[m] <= dx_c;
      dy1[m] <= dy_c;
      r1[m]  <= r[m];
      en1[m] <= (CNT_W'(m) < active_count) && (r[m] != '0);
    end

    // Square and sum.
    always_ff @(posedge clk) begin
      lanes[m].en <= en1[m];
      lanes[m].d2 <= D2_W'(dx1[m]) * D2_W'(dx1[m]) + D2_W'(dy1[m]) * D2_W'(dy1[m]);
      lanes[m].r2 <= R2_W'(r1[m]) * R2_W'(r1[m]);
    end
  end

endmodule

### rtl/rcam_select.sv
// ----------------------------------------------------------------------------
// rcam_select
// Picks the lowest slot whose squared distance lies below its squared radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcam_select import rcam_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  v2,
  input  lane_t lanes [MAX_CIRCLES],
  output logic  v3,
  output sel_t  sel
);

  sel_t pick;

  // Walk from the top so the lowest matching slot wins.
  always_comb begin
    pick = '0;
    for (int m = MAX_CIRCLES - 1; m >= 0; m--) begin
      if (lanes[m].en && (lanes[m].d2 < D2_W'(lanes[m].r2))) begin
        pick.hit  = 1'b1;
        pick.slot = SLOT_W'(m);
        pick.d2   = lanes[m].d2;
        pick.r2   = lanes[m].r2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sel <= pick;
  end

endmodule

### rtl/rcam_alpha.sv
// ----------------------------------------------------------------------------
// rcam_alpha
// Bit-per-stage search for the largest a with a*a*r2 <= 65025*d2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcam_alpha import rcam_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      v3,
  input  sel_t      sel,
  output logic      done,
  output out_item_t result
);

  localparam int NST = ALPHA_W + 1;

  logic               st_v    [NST];
  logic               st_hit  [NST];
  logic [SLOT_W-1:0]  st_slot [NST];
  logic [ALPHA_W-1:0] st_a    [NST];
  logic [ACC_W-1:0]   st_a2r  [NST];
  logic [AR_W-1:0]    st_ar   [NST];
  logic [LIM_W-1:0]   st_lim  [NST];
  logic [R2_W-1:0]    st_r2   [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else begin
      st_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    st_hit[0]  <= sel.hit;
    st_slot[0] <= sel.slot;
    st_a[0]    <= '0;
    st_a2r[0]  <= '0;
    st_ar[0]   <= '0;
    st_lim[0]  <= LIM_W'(sel.d2) * LIM_W'(ALPHA_SQ);
    st_r2[0]   <= sel.r2;
  end

  // Trying bit b: (a+2^b)^2 r2 = a^2 r2 + 2^(b+1) a r2 + 2^(2b) r2.
  for (genvar k = 0; k < ALPHA_W; k++) begin : g_bit
    localparam int B = ALPHA_W - 1 - k;
    logic [ACC_W-1:0] cand;
    logic             take;

    assign cand = st_a2r[k] + (ACC_W'(st_ar[k]) << (B + 1)) + (ACC_W'(st_r2[k]) << (2 * B));
    assign take = cand <= ACC_W'(st_lim[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else begin
        st_v[k+1] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      st_hit[k+1]  <= st_hit[k];
      st_slot[k+1] <= st_slot[k];
      st_lim[k+1]  <= st_lim[k];
      st_r2[k+1]   <= st_r2[k];
      if (take) begin
        st_a[k+1]   <= st_a[k] | ALPHA_W'(1 << B);
        st_a2r[k+1] <= cand;
        st_ar[k+1]  <= st_ar[k] + (AR_W'(st_r2[k]) << B);
      end else begin
        st_a[k+1]   <= st_a[k];
        st_a2r[k+1] <= st_a2r[k];
        st_ar[k+1]  <= st_ar[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    result.alpha        <= st_hit[NST-1] ? st_a[NST-1] : ALPHA_W'(FULL_ALPHA);
    result.inside_res   <= st_hit[NST-1];
    result.matched_slot <= st_hit[NST-1] ? st_slot[NST-1] : '0;
  end

endmodule

### rtl/radial_circle_alpha_mask_top.sv
// A shade beat shows on result with done once it has passed the table, select and alpha stages in turn.
// Throughput: one beat per cycle of any kind; busy stays low, set by the 13-stage pipeline.
// Table writes and count updates take effect at their accept edge and give no result.
// Reset (rst, synchronous) clears the circle table, the active count and all valid bits.
// ----------------------------------------------------------------------------
// radial_circle_alpha_mask_top
// Shades pixels against a table of circles: alpha from distance over radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radial_circle_alpha_mask_top_assert.svh"

module radial_circle_alpha_mask_top import rcam_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      done,
  output out_item_t result
);

  logic  acc;
  logic  v2;
  logic  v3;
  lane_t lanes [MAX_CIRCLES];
  sel_t  sel;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  rcam_table u_table (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .item  (item),
    .v2    (v2),
    .lanes (lanes)
  );

  rcam_select u_select (
    .clk   (clk),
    .rst   (rst),
    .v2    (v2),
    .lanes (lanes),
    .v3    (v3),
    .sel   (sel)
  );

  rcam_alpha u_alpha (
    .clk    (clk),
    .rst    (rst),
    .v3     (v3),
    .sel    (sel),
    .done   (done),
    .result (result)
  );

  `RCAM_ASSERT_IMP(a_miss_slot, done && !result.inside_res, result.matched_slot == '0, "miss with nonzero slot")
  `RCAM_ASSERT_IMP(a_miss_alpha, done && !result.inside_res, result.alpha == ALPHA_W'(FULL_ALPHA), "miss without full alpha")
  `RCAM_ASSERT_IMP(a_hit_alpha, done && result.inside_res, result.alpha != ALPHA_W'(FULL_ALPHA), "hit with full alpha")
  `RCAM_ASSERT_NXT(a_sel_flow, v3, u_alpha.st_v[0], "select beat dropped")

endmodule
